### rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// shared widths, codes and types of the support foot estimator
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SNS_IDX_W   = $clog2(NUM_SENSORS);
  localparam int SAMPLE_W    = 16;
  localparam int REG_W       = 15;
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_W     = FRAC_BITS + 2;
  localparam int WEIGHT_W    = REG_W + 1;
  localparam int PROD_W      = WEIGHT_W + RATIO_W;
  localparam int WSUM_W      = PROD_W + 2;
  localparam int TOTAL_W     = RATIO_W + 3;
  localparam int OUT_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int DIV_NUM_W   = WSUM_W;
  localparam int DIV_DEN_W   = TOTAL_W - 1;
  localparam int DIV_Q_W     = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_Q_W + 1);
  localparam int EST_Q_BITS  = OUT_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // outer sensors: left front-left, left back-left, right front-right, right back-right
  localparam logic [NUM_SENSORS-1:0] SENSOR_OUTER = 8'b1010_0101;

  localparam logic [REG_W-1:0] CLAMP_CEILING_RST = 15'd20480;
  localparam logic [REG_W-1:0] OUTER_WEIGHT_RST  = 15'd26214;
  localparam logic [REG_W-1:0] INNER_WEIGHT_RST  = 15'd9830;

  localparam logic signed [RATIO_W-1:0] RATIO_POS_ONE = RATIO_W'(1) << FRAC_BITS;
  localparam logic signed [RATIO_W-1:0] RATIO_NEG_ONE = -RATIO_POS_ONE;

  localparam logic signed [OUT_W-1:0] EST_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] EST_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAMP_CEILING = 2'd0,
    CFG_OUTER_WEIGHT  = 2'd1,
    CFG_INNER_WEIGHT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SNS_SKIP,
    SNS_DIV,
    SNS_SAT
  } sns_mode_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SENSOR,
    BK_DWAIT,
    BK_MUL,
    BK_ACC,
    BK_ABS,
    BK_FINAL,
    BK_FWAIT,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [REG_W-1:0] clamp_ceiling;
    logic [REG_W-1:0] outer_weight;
    logic [REG_W-1:0] inner_weight;
  } cfg_t;

  typedef struct packed {
    sns_mode_t           mode;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [REG_W-1:0]    peak;
  } sns_rec_t;

  typedef sns_rec_t [NUM_SENSORS-1:0] frame_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### rtl/sfe_divider.sv
// ----------------------------------------------------------------------------
// sfe_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_divider import sfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] dsh_r, dsh_nxt;
  logic [DIV_Q_W-1:0]   quot_r, quot_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.qbits;
      rem_nxt  = req.num;
      dsh_nxt  = DIV_NUM_W'(req.den) << (req.qbits - 1'b1);
      quot_nxt = '0;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt  = rem_r - dsh_r;
        quot_nxt = {quot_r[DIV_Q_W-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[DIV_Q_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

### rtl/sfe_queue.sv
// ----------------------------------------------------------------------------
// sfe_queue
// short frame queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_queue import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  frame_t    push_frame,
  input  logic      pop,
  output frame_t    head,
  output q_status_t status
);

  frame_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

`default_nettype wire

### rtl/sfe_front.sv
// ----------------------------------------------------------------------------
// sfe_front
// accepts a frame, clamps samples, tracks peaks and classifies each sensor
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_front import sfe_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] samples,
  input  logic [REG_W-1:0]                    clamp_ceiling,
  input  q_status_t                           q_status,
  output logic                                push,
  output frame_t                              push_frame
);

  logic [REG_W-1:0] peak_r   [NUM_SENSORS];
  logic [REG_W-1:0] peak_nxt [NUM_SENSORS];

  logic signed [SAMPLE_W-1:0] val  [NUM_SENSORS];
  logic [REG_W-1:0]           pk   [NUM_SENSORS];
  logic signed [SAMPLE_W-1:0] ceil_s;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign ceil_s   = $signed({1'b0, clamp_ceiling});

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      val[i] = $signed(samples[i]);
      if (val[i] > ceil_s) begin
        val[i] = ceil_s;
      end
      pk[i] = (val[i] > $signed({1'b0, peak_r[i]})) ? val[i][REG_W-1:0] : peak_r[i];
      peak_nxt[i] = push ? pk[i] : peak_r[i];

      push_frame[i].neg  = val[i][SAMPLE_W-1];
      push_frame[i].mag  = val[i][SAMPLE_W-1] ? SAMPLE_W'(-val[i]) : val[i];
      push_frame[i].peak = pk[i];
      if (pk[i] == '0) begin
        push_frame[i].mode = SNS_SKIP;
      end else if (val[i][SAMPLE_W-1] &&
                   ({1'b0, push_frame[i].mag} >= {pk[i], 2'b00} >> 1)) begin
        push_frame[i].mode = SNS_SAT;
      end else begin
        push_frame[i].mode = SNS_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (!rst_n) begin
        peak_r[i] <= '0;
      end else begin
        peak_r[i] <= peak_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sfe_back.sv
// ----------------------------------------------------------------------------
// sfe_back
// per sensor ratio, weighted sums, final quotient and output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_back import sfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_status_t               q_status,
  input  frame_t                  head,
  output logic                    pop,
  input  logic [REG_W-1:0]        outer_weight,
  input  logic [REG_W-1:0]        inner_weight,
  output div_req_t                div_req,
  input  div_rsp_t                div_rsp,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_support_foot,
  output logic                    out_no_contact
);

  back_state_t state_r, state_nxt;

  logic [SNS_IDX_W-1:0]       idx_r, idx_nxt;
  logic signed [RATIO_W-1:0]  ratio_r, ratio_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [TOTAL_W-1:0]  total_r, total_nxt;
  logic signed [WSUM_W-1:0]   wsum_r, wsum_nxt;
  logic [DIV_NUM_W-1:0]       wmag_r, wmag_nxt;
  logic [DIV_DEN_W-1:0]       tmag_r, tmag_nxt;
  logic                       fneg_r, fneg_nxt;
  logic signed [OUT_W-1:0]    est_r, est_nxt;
  logic                       nc_r, nc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]    out_sf_r, out_sf_nxt;
  logic                       out_nc_r, out_nc_nxt;

  sns_rec_t                   rec;
  logic                       last;
  logic                       out_free;
  logic                       fsat;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [RATIO_W-1:0]  qx;
  logic [EST_Q_BITS-1:0]      q16;
  logic signed [TOTAL_W-1:0]  tneg;

  assign rec      = head[idx_r];
  assign last     = (idx_r == SNS_IDX_W'(NUM_SENSORS - 1));
  assign out_free = !out_valid_r || !out_stall;
  assign fsat     = (wmag_r >= {tmag_r, {(DIV_NUM_W-DIV_DEN_W){1'b0}}});
  assign qx       = $signed({1'b0, div_rsp.quot});
  assign q16      = div_rsp.quot[EST_Q_BITS-1:0];
  assign tneg     = -total_r;

  always_comb begin
    weight = $signed({1'b0, SENSOR_OUTER[idx_r] ? outer_weight : inner_weight});
    if (idx_r >= SNS_IDX_W'(NUM_SENSORS / 2)) begin
      weight = -weight;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) state_nxt = BK_SENSOR;
      end
      BK_SENSOR: begin
        unique case (rec.mode)
          SNS_DIV: state_nxt = BK_DWAIT;
          SNS_SAT: state_nxt = BK_MUL;
          default: state_nxt = last ? BK_ABS : BK_SENSOR;
        endcase
      end
      BK_DWAIT: begin
        if (div_rsp.done) state_nxt = BK_MUL;
      end
      BK_MUL:   state_nxt = BK_ACC;
      BK_ACC:   state_nxt = last ? BK_ABS : BK_SENSOR;
      BK_ABS:   state_nxt = (total_r == '0) ? BK_OUT : BK_FINAL;
      BK_FINAL: state_nxt = fsat ? BK_OUT : BK_FWAIT;
      BK_FWAIT: begin
        if (div_rsp.done) state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    ratio_nxt     = ratio_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    wsum_nxt      = wsum_r;
    wmag_nxt      = wmag_r;
    tmag_nxt      = tmag_r;
    fneg_nxt      = fneg_r;
    est_nxt       = est_r;
    nc_nxt        = nc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sf_nxt    = out_sf_r;
    out_nc_nxt    = out_nc_r;
    pop           = 1'b0;
    div_req       = '0;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt   = '0;
        total_nxt = '0;
        wsum_nxt  = '0;
      end
      BK_SENSOR: begin
        unique case (rec.mode)
          SNS_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({rec.mag, {FRAC_BITS{1'b0}}});
            div_req.den   = DIV_DEN_W'(rec.peak);
            div_req.qbits = DIV_CNT_W'(DIV_Q_W);
          end
          SNS_SAT: ratio_nxt = RATIO_NEG_ONE;
          default: idx_nxt = idx_r + 1'b1;
        endcase
      end
      BK_DWAIT: begin
        if (rec.neg) begin
          ratio_nxt = (qx > RATIO_POS_ONE) ? RATIO_NEG_ONE : -qx;
        end else begin
          ratio_nxt = qx;
        end
      end
      BK_MUL: begin
        prod_nxt  = weight * ratio_r;
        total_nxt = total_r + TOTAL_W'(ratio_r);
      end
      BK_ACC: begin
        wsum_nxt = wsum_r + WSUM_W'(prod_r);
        idx_nxt  = idx_r + 1'b1;
      end
      BK_ABS: begin
        wmag_nxt = wsum_r[WSUM_W-1] ? DIV_NUM_W'(-wsum_r) : DIV_NUM_W'(wsum_r);
        tmag_nxt = total_r[TOTAL_W-1] ? tneg[DIV_DEN_W-1:0] : total_r[DIV_DEN_W-1:0];
        fneg_nxt = wsum_r[WSUM_W-1] ^ total_r[TOTAL_W-1];
        nc_nxt   = (total_r == '0);
        est_nxt  = '0;
      end
      BK_FINAL: begin
        if (fsat) begin
          est_nxt = fneg_r ? EST_MIN : EST_MAX;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = wmag_r;
          div_req.den   = tmag_r;
          div_req.qbits = DIV_CNT_W'(EST_Q_BITS);
        end
      end
      BK_FWAIT: begin
        if (!fneg_r) begin
          est_nxt = (q16 > EST_Q_BITS'(EST_MAX)) ? EST_MAX : $signed(q16);
        end else begin
          est_nxt = (q16 > EST_Q_BITS'(EST_MIN)) ? EST_MIN : $signed(-q16);
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sf_nxt    = est_r;
          out_nc_nxt    = nc_r;
          pop           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    ratio_r  <= ratio_nxt;
    prod_r   <= prod_nxt;
    total_r  <= total_nxt;
    wsum_r   <= wsum_nxt;
    wmag_r   <= wmag_nxt;
    tmag_r   <= tmag_nxt;
    fneg_r   <= fneg_nxt;
    est_r    <= est_nxt;
    nc_r     <= nc_nxt;
    out_sf_r <= out_sf_nxt;
    out_nc_r <= out_nc_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_support_foot = out_sf_r;
  assign out_no_contact   = out_nc_r;

endmodule

`default_nettype wire

### rtl/support_foot_estimator_unit.sv
// ----------------------------------------------------------------------------
// support_foot_estimator_unit
// support foot estimate from eight foot pressure samples per frame
// ----------------------------------------------------------------------------
//
//   channel  handshake          beat
//   in       in_valid/in_stall  eight Q3.12 samples
//   out      out_valid/out_stall support_foot Q1.15, no_contact
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// the back end runs a frame through the shared divider: 17 quotient bits for
// each sensor that needs a division and 16 for the final quotient
// the front takes a frame per cycle while the two entry queue has room
// reset clears the peaks, the queue and the output valid flag, sets the config
// registers to their defaults; a result waits in the output register while stalled
//
`default_nettype none

module support_foot_estimator_unit import sfe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_left_front_left,
  input  logic signed [SAMPLE_W-1:0] in_left_front_right,
  input  logic signed [SAMPLE_W-1:0] in_left_back_left,
  input  logic signed [SAMPLE_W-1:0] in_left_back_right,
  input  logic signed [SAMPLE_W-1:0] in_right_front_left,
  input  logic signed [SAMPLE_W-1:0] in_right_front_right,
  input  logic signed [SAMPLE_W-1:0] in_right_back_left,
  input  logic signed [SAMPLE_W-1:0] in_right_back_right,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    out_support_foot,
  output logic                       out_no_contact,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [REG_W-1:0]           cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  frame_t    push_frame;
  frame_t    head;
  logic      push;
  logic      pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] samples;

  assign cfg_ready = 1'b1;
  assign samples   = {in_right_back_right, in_right_back_left,
                      in_right_front_right, in_right_front_left,
                      in_left_back_right, in_left_back_left,
                      in_left_front_right, in_left_front_left};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLAMP_CEILING: cfg_nxt.clamp_ceiling = cfg_data;
        CFG_OUTER_WEIGHT:  cfg_nxt.outer_weight  = cfg_data;
        CFG_INNER_WEIGHT:  cfg_nxt.inner_weight  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clamp_ceiling <= CLAMP_CEILING_RST;
      cfg_r.outer_weight  <= OUTER_WEIGHT_RST;
      cfg_r.inner_weight  <= INNER_WEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .samples       (samples),
    .clamp_ceiling (cfg_r.clamp_ceiling),
    .q_status      (q_status),
    .push          (push),
    .push_frame    (push_frame)
  );

  sfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  sfe_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head             (head),
    .pop              (pop),
    .outer_weight     (cfg_r.outer_weight),
    .inner_weight     (cfg_r.inner_weight),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_support_foot (out_support_foot),
    .out_no_contact   (out_no_contact)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_pop_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("frame retired without a result beat");

  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_contact) |-> (out_support_foot == '0))
    else $error("no contact beat with nonzero estimate");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after a start");

endmodule

`default_nettype wire
